// ===== src/kv_tlv_pkg.sv =====
// Shared types, codes and sizes for the tag-length-value record parser.
package kv_tlv_pkg;

    // Record type codes carried in the low three bits of the header word.
    localparam logic [2:0] REC_INT32 = 3'd0;
    localparam logic [2:0] REC_INT64 = 3'd1;
    localparam logic [2:0] REC_BYTES = 3'd2;

    // Result kind codes.
    localparam logic [2:0] KIND_INT32     = 3'd0;
    localparam logic [2:0] KIND_INT64     = 3'd1;
    localparam logic [2:0] KIND_BYTES_HDR = 3'd2;
    localparam logic [2:0] KIND_PAYLOAD   = 3'd3;
    localparam logic [2:0] KIND_OK        = 3'd4;
    localparam logic [2:0] KIND_MALFORMED = 3'd5;

    // Result queue sizing. One input byte pushes at most two results.
    localparam int MAX_PUSH   = 2;
    localparam int FIFO_DEPTH = 4;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);
    localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

    typedef struct packed {
        logic [2:0]  kind;
        logic [12:0] record_key;
        logic [63:0] record_value;
        logic        last_of_run;
    } t_result;

    // Results produced by one accepted byte, in delivery order.
    typedef struct packed {
        logic [1:0] count;
        t_result    r0;
        t_result    r1;
    } t_push;

endpackage

// ===== src/kv_tlv_parse_core.sv =====
// Parse state registers and the per-byte next-state and result logic.
module kv_tlv_parse_core (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic                 i_cfg_wdata,
    input  logic                 i_accept,
    input  logic [7:0]           i_data_byte,
    input  logic                 i_end_of_buffer,
    output kv_tlv_pkg::t_push    o_push
);

    typedef enum logic [5:0] {
        PH_HDR  = 6'b000001,
        PH_V32  = 6'b000010,
        PH_V64  = 6'b000100,
        PH_LEN  = 6'b001000,
        PH_PAY  = 6'b010000,
        PH_SKIP = 6'b100000
    } t_phase;

    t_phase      r_phase,        n_phase;
    logic [2:0]  r_byte_index,   n_byte_index;
    logic [15:0] r_header_hold,  n_header_hold;
    logic [63:0] r_value_acc,    n_value_acc;
    logic [31:0] r_payload_rem,  n_payload_rem;
    logic        r_error_seen,   n_error_seen;
    logic        r_big_endian;

    always_comb begin
        logic [15:0]         v_hh;
        logic [63:0]         v_acc;
        logic [31:0]         v_rem;
        logic [3:0]          v_total;
        logic                v_rec_vld;
        logic                v_ok;
        kv_tlv_pkg::t_result v_rec;
        kv_tlv_pkg::t_result v_stat;

        n_phase       = r_phase;
        n_byte_index  = r_byte_index;
        n_header_hold = r_header_hold;
        n_value_acc   = r_value_acc;
        n_payload_rem = r_payload_rem;
        n_error_seen  = r_error_seen;
        v_hh          = r_header_hold;
        v_acc         = r_value_acc;
        v_rem         = r_payload_rem;
        v_total       = 4'd4;
        v_rec_vld     = 1'b0;
        v_ok          = 1'b0;
        v_rec.kind         = kv_tlv_pkg::KIND_INT32;
        v_rec.record_key   = r_header_hold[15:3];
        v_rec.record_value = 64'd0;
        v_rec.last_of_run  = 1'b0;
        v_stat.kind         = kv_tlv_pkg::KIND_OK;
        v_stat.record_key   = 13'd0;
        v_stat.record_value = 64'd0;
        v_stat.last_of_run  = 1'b1;
        o_push.count = 2'd0;
        o_push.r0    = v_rec;
        o_push.r1    = v_stat;

        if (i_accept) begin
            case (r_phase)
                PH_HDR: begin
                    if (r_big_endian) begin
                        v_hh = {r_header_hold[7:0], i_data_byte};
                    end else if (r_byte_index[0]) begin
                        v_hh = r_header_hold | {i_data_byte, 8'h00};
                    end else begin
                        v_hh = r_header_hold | {8'h00, i_data_byte};
                    end
                    n_header_hold = v_hh;
                    if (r_byte_index == 3'd0) begin
                        n_byte_index = 3'd1;
                    end else begin
                        n_byte_index = 3'd0;
                        n_value_acc  = 64'd0;
                        case (v_hh[2:0])
                            kv_tlv_pkg::REC_INT32: n_phase = PH_V32;
                            kv_tlv_pkg::REC_INT64: n_phase = PH_V64;
                            kv_tlv_pkg::REC_BYTES: n_phase = PH_LEN;
                            default: begin
                                n_phase      = PH_SKIP;
                                n_error_seen = 1'b1;
                            end
                        endcase
                    end
                end
                PH_V32, PH_V64, PH_LEN: begin
                    if (r_big_endian) begin
                        v_acc = {r_value_acc[55:0], i_data_byte};
                    end else begin
                        for (int k = 0; k < 8; k++) begin
                            v_acc[8*k +: 8] = r_value_acc[8*k +: 8] |
                                ((r_byte_index == 3'(k)) ? i_data_byte : 8'h00);
                        end
                    end
                    v_total = (r_phase == PH_V64) ? 4'd8 : 4'd4;
                    if (({1'b0, r_byte_index} + 4'd1) >= v_total) begin
                        v_rec_vld     = 1'b1;
                        n_phase       = PH_HDR;
                        n_byte_index  = 3'd0;
                        n_header_hold = 16'd0;
                        n_value_acc   = 64'd0;
                        if (r_phase == PH_V32) begin
                            v_rec.kind         = kv_tlv_pkg::KIND_INT32;
                            v_rec.record_value = {{32{v_acc[31]}}, v_acc[31:0]};
                        end else if (r_phase == PH_V64) begin
                            v_rec.kind         = kv_tlv_pkg::KIND_INT64;
                            v_rec.record_value = v_acc;
                        end else begin
                            v_rec.kind         = kv_tlv_pkg::KIND_BYTES_HDR;
                            v_rec.record_value = {32'd0, v_acc[31:0]};
                            n_payload_rem      = v_acc[31:0];
                            if (v_acc[31:0] != 32'd0) begin
                                // Keep the header so payload results carry the key.
                                n_phase       = PH_PAY;
                                n_header_hold = r_header_hold;
                            end
                        end
                    end else begin
                        n_value_acc  = v_acc;
                        n_byte_index = r_byte_index + 3'd1;
                    end
                end
                PH_PAY: begin
                    v_rec_vld          = 1'b1;
                    v_rec.kind         = kv_tlv_pkg::KIND_PAYLOAD;
                    v_rec.record_value = {56'd0, i_data_byte};
                    v_rem              = r_payload_rem - 32'd1;
                    n_payload_rem      = v_rem;
                    if (v_rem == 32'd0) begin
                        n_phase       = PH_HDR;
                        n_byte_index  = 3'd0;
                        n_header_hold = 16'd0;
                        n_value_acc   = 64'd0;
                    end
                end
                default: begin
                    n_phase      = PH_SKIP;
                    n_error_seen = 1'b1;
                end
            endcase

            if (i_end_of_buffer) begin
                v_ok = (n_phase == PH_HDR) && (n_byte_index == 3'd0) && !n_error_seen;
                v_stat.kind   = v_ok ? kv_tlv_pkg::KIND_OK : kv_tlv_pkg::KIND_MALFORMED;
                n_phase       = PH_HDR;
                n_byte_index  = 3'd0;
                n_header_hold = 16'd0;
                n_value_acc   = 64'd0;
                n_payload_rem = 32'd0;
                n_error_seen  = 1'b0;
            end

            if (v_rec_vld && i_end_of_buffer) begin
                o_push.count = 2'd2;
                o_push.r0    = v_rec;
                o_push.r1    = v_stat;
            end else if (v_rec_vld) begin
                v_rec.last_of_run = 1'b1;
                o_push.count      = 2'd1;
                o_push.r0         = v_rec;
            end else if (i_end_of_buffer) begin
                o_push.count = 2'd1;
                o_push.r0    = v_stat;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_HDR;
            r_byte_index  <= 3'd0;
            r_header_hold <= 16'd0;
            r_value_acc   <= 64'd0;
            r_payload_rem <= 32'd0;
            r_error_seen  <= 1'b0;
            r_big_endian  <= 1'b1;
        end else begin
            r_phase       <= n_phase;
            r_byte_index  <= n_byte_index;
            r_header_hold <= n_header_hold;
            r_value_acc   <= n_value_acc;
            r_payload_rem <= n_payload_rem;
            r_error_seen  <= n_error_seen;
            if (i_cfg_we) begin
                r_big_endian <= i_cfg_wdata;
            end
        end
    end

endmodule

// ===== src/kv_tlv_result_fifo.sv =====
// Four-entry result queue that takes up to two results and gives one per cycle unless stalled.
module kv_tlv_result_fifo (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  kv_tlv_pkg::t_push     i_push,
    input  logic                  i_stall,
    output logic                  o_valid,
    output kv_tlv_pkg::t_result   o_data,
    output logic                  o_no_room
);

    kv_tlv_pkg::t_result                 r_mem [0:kv_tlv_pkg::FIFO_DEPTH-1];
    logic [kv_tlv_pkg::PTR_W-1:0]        r_wr_ptr, n_wr_ptr;
    logic [kv_tlv_pkg::PTR_W-1:0]        r_rd_ptr, n_rd_ptr;
    logic [kv_tlv_pkg::CNT_W-1:0]        r_count,  n_count;
    logic                                w_pop;

    assign o_valid   = (r_count != '0);
    assign o_data    = r_mem[r_rd_ptr];
    assign w_pop     = o_valid && !i_stall;
    // Accept a byte only when room for its largest burst is guaranteed.
    assign o_no_room = (r_count > kv_tlv_pkg::CNT_W'(kv_tlv_pkg::FIFO_DEPTH -
                                                       kv_tlv_pkg::MAX_PUSH));

    always_comb begin
        n_wr_ptr = r_wr_ptr + kv_tlv_pkg::PTR_W'(i_push.count);
        n_rd_ptr = r_rd_ptr + kv_tlv_pkg::PTR_W'(w_pop);
        n_count  = r_count + kv_tlv_pkg::CNT_W'(i_push.count)
                           - kv_tlv_pkg::CNT_W'(w_pop);
    end

    always_ff @(posedge i_clk) begin
        if (i_push.count != 2'd0) begin
            r_mem[r_wr_ptr] <= i_push.r0;
        end
        if (i_push.count == 2'd2) begin
            r_mem[r_wr_ptr + kv_tlv_pkg::PTR_W'(1)] <= i_push.r1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    a_count_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= kv_tlv_pkg::CNT_W'(kv_tlv_pkg::FIFO_DEPTH))
        else $error("result queue count out of range");

    a_push_has_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push.count != 2'd0) |-> !o_no_room)
        else $error("results pushed without room");

    a_ptr_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        kv_tlv_pkg::PTR_W'(r_wr_ptr - r_rd_ptr) == kv_tlv_pkg::PTR_W'(r_count))
        else $error("queue pointers disagree with count");

endmodule

// ===== src/kv_tlv_record_parser_unit.sv =====
// Top level of the tag-length-value record parser: parse core and result queue.
//
// Usage: buffer bytes arrive on the input channel (i_in_valid, o_in_stall,
// i_data_byte, i_end_of_buffer), one byte per transfer, with i_end_of_buffer
// set on the buffer's final byte. Results leave on the output channel
// (o_out_valid, i_out_stall, o_kind, o_record_key, o_record_value,
// o_last_of_run), one result per transfer. A byte causes zero, one or two
// results; o_last_of_run marks the final result caused by a byte.
// A result is written to the result queue when its byte is taken and is
// offered once the results ahead of it have left. Throughput: one byte per
// cycle unless the input stalls; the queue drains one result per cycle unless
// the receiver stalls, so a byte's record and buffer status leave in turn.
// The field order is set by i_cfg_we / i_cfg_wdata (1 = big-endian), to be
// written only while the block is idle; reset selects big-endian.
// Reset (synchronous, active low) returns the parser to the start of a
// buffer and empties the result queue.
// When the receiver stalls, results wait in a four-entry queue; the input
// stalls once fewer than two entries are free.
module kv_tlv_record_parser_unit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic                i_cfg_wdata,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic [7:0]          i_data_byte,
    input  logic                i_end_of_buffer,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic [2:0]          o_kind,
    output logic [12:0]         o_record_key,
    output logic signed [63:0]  o_record_value,
    output logic                o_last_of_run
);

    logic                 w_accept;
    logic                 w_no_room;
    kv_tlv_pkg::t_push    w_push;
    kv_tlv_pkg::t_result  w_head;

    // The input stalls only on queue room, never on the input valid.
    assign o_in_stall = w_no_room;
    assign w_accept   = i_in_valid && !w_no_room;

    kv_tlv_parse_core u_core (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_accept        (w_accept),
        .i_data_byte     (i_data_byte),
        .i_end_of_buffer (i_end_of_buffer),
        .o_push          (w_push)
    );

    kv_tlv_result_fifo u_fifo (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (w_push),
        .i_stall   (i_out_stall),
        .o_valid   (o_out_valid),
        .o_data    (w_head),
        .o_no_room (w_no_room)
    );

    assign o_kind         = w_head.kind;
    assign o_record_key   = w_head.record_key;
    assign o_record_value = w_head.record_value;
    assign o_last_of_run  = w_head.last_of_run;

endmodule

// ===== dv/kv_tlv_record_parser_unit_tb.sv =====
// Self-checking testbench for the tag-length-value record parser top level.
`timescale 1ns / 1ps

// Tracks the parse of the byte stream and holds the results it must produce, in order.
class t_tlv_record_scoreboard;

    typedef enum logic [5:0] {
        AWAIT_HEADER = 6'b000001,
        IN_INT32     = 6'b000010,
        IN_INT64     = 6'b000100,
        IN_LENGTH    = 6'b001000,
        IN_PAYLOAD   = 6'b010000,
        SKIPPING     = 6'b100000
    } t_parse_phase;

    bit                   big_endian;
    t_parse_phase         phase;
    logic [2:0]           field_pos;
    logic [15:0]          header_word;
    logic [63:0]          field_acc;
    logic [31:0]          bytes_left;
    bit                   bad_seen;
    kv_tlv_pkg::t_result  pending_results[$];
    int                   mismatches;

    function new();
        big_endian = 1'b1;
        mismatches = 0;
        clear_parse();
    endfunction

    function void clear_parse();
        phase       = AWAIT_HEADER;
        field_pos   = '0;
        header_word = '0;
        field_acc   = '0;
        bytes_left  = '0;
        bad_seen    = 1'b0;
    endfunction

    function void next_record();
        phase       = AWAIT_HEADER;
        field_pos   = '0;
        header_word = '0;
        field_acc   = '0;
    endfunction

    function void set_order(bit be);
        big_endian = be;
    endfunction

    function int pending();
        return pending_results.size();
    endfunction

    function void add_result(logic [2:0] kind, logic [12:0] key, logic [63:0] value);
        kv_tlv_pkg::t_result r;
        r.kind         = kind;
        r.record_key   = key;
        r.record_value = value;
        r.last_of_run  = 1'b0;
        pending_results.push_back(r);
    endfunction

    // Called for every accepted input byte; appends the results that byte causes.
    function void parse_byte(logic [7:0] b, logic eob);
        logic [12:0] key;
        int          made;
        int          total;
        key  = header_word[15:3];
        made = pending_results.size();
        case (phase)
            AWAIT_HEADER: begin
                if (big_endian) begin
                    header_word = {header_word[7:0], b};
                end else begin
                    header_word = header_word | (16'(b) << (8 * field_pos[0]));
                end
                if (field_pos == 0) begin
                    field_pos = 3'd1;
                end else begin
                    field_pos = '0;
                    field_acc = '0;
                    case (header_word[2:0])
                        kv_tlv_pkg::REC_INT32: phase = IN_INT32;
                        kv_tlv_pkg::REC_INT64: phase = IN_INT64;
                        kv_tlv_pkg::REC_BYTES: phase = IN_LENGTH;
                        default: begin
                            phase    = SKIPPING;
                            bad_seen = 1'b1;
                        end
                    endcase
                end
            end
            IN_INT32, IN_INT64, IN_LENGTH: begin
                total = (phase == IN_INT64) ? 8 : 4;
                if (big_endian) begin
                    field_acc = {field_acc[55:0], b};
                end else begin
                    field_acc = field_acc | (64'(b) << (8 * field_pos));
                end
                if (int'(field_pos) + 1 >= total) begin
                    if (phase == IN_INT32) begin
                        add_result(kv_tlv_pkg::KIND_INT32, key,
                                   {{32{field_acc[31]}}, field_acc[31:0]});
                        next_record();
                    end else if (phase == IN_INT64) begin
                        add_result(kv_tlv_pkg::KIND_INT64, key, field_acc);
                        next_record();
                    end else begin
                        bytes_left = field_acc[31:0];
                        add_result(kv_tlv_pkg::KIND_BYTES_HDR, key, {32'd0, bytes_left});
                        field_pos = '0;
                        field_acc = '0;
                        if (bytes_left == 0) begin
                            next_record();
                        end else begin
                            phase = IN_PAYLOAD;
                        end
                    end
                end else begin
                    field_pos = field_pos + 3'd1;
                end
            end
            IN_PAYLOAD: begin
                add_result(kv_tlv_pkg::KIND_PAYLOAD, key, {56'd0, b});
                bytes_left = bytes_left - 32'd1;
                if (bytes_left == 0) begin
                    next_record();
                end
            end
            default: begin
                phase    = SKIPPING;
                bad_seen = 1'b1;
            end
        endcase
        if (eob) begin
            if (phase == AWAIT_HEADER && field_pos == 0 && !bad_seen) begin
                add_result(kv_tlv_pkg::KIND_OK, '0, '0);
            end else begin
                add_result(kv_tlv_pkg::KIND_MALFORMED, '0, '0);
            end
            clear_parse();
        end
        if (pending_results.size() > made) begin
            pending_results[pending_results.size() - 1].last_of_run = 1'b1;
        end
    endfunction

    function void report_failure(string what);
        mismatches++;
        if (mismatches <= 10) begin
            $display("ERROR at %0t: %s", $realtime, what);
        end
    endfunction

    // Called for every result transfer; compares it with the oldest pending result.
    function void check_result(logic [2:0] kind, logic [12:0] key, logic [63:0] value,
                               logic last);
        kv_tlv_pkg::t_result want;
        if (pending_results.size() == 0) begin
            report_failure($sformatf(
                "result with nothing pending: kind %0d key %0d value %h last %0b",
                kind, key, value, last));
            return;
        end
        want = pending_results.pop_front();
        if (kind !== want.kind || key !== want.record_key || value !== want.record_value
                || last !== want.last_of_run) begin
            report_failure($sformatf({"result mismatch: kind %0d/%0d key %0d/%0d ",
                                      "value %h/%h last %0b/%0b (expected/actual)"},
                                     want.kind, kind, want.record_key, key,
                                     want.record_value, value, want.last_of_run, last));
        end
    endfunction

endclass

module kv_tlv_record_parser_unit_tb;

    // A run far slower than any correct one is cut off here.
    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASE_BYTES = 160;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_cfg_we = 1'b0;
    logic               i_cfg_wdata = 1'b1;
    logic               i_in_valid = 1'b0;
    logic               o_in_stall;
    logic [7:0]         i_data_byte = 8'd0;
    logic               i_end_of_buffer = 1'b0;
    logic               o_out_valid;
    logic               i_out_stall = 1'b0;
    logic [2:0]         o_kind;
    logic [12:0]        o_record_key;
    logic signed [63:0] o_record_value;
    logic               o_last_of_run;

    t_tlv_record_scoreboard scoreboard = new();

    // Bytes of the buffer under construction and the field order used to encode it.
    logic [7:0] frame_bytes[$];
    bit         encode_big = 1'b1;
    bit         sender_eager = 1'b0;
    int         cycle_count = 0;

    kv_tlv_record_parser_unit u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_data_byte     (i_data_byte),
        .i_end_of_buffer (i_end_of_buffer),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_kind          (o_kind),
        .o_record_key    (o_record_key),
        .o_record_value  (o_record_value),
        .o_last_of_run   (o_last_of_run)
    );

    always #2 i_clk = ~i_clk;

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("kv_tlv_record_parser_unit_tb failed");
            $finish;
        end
    end

    // Every result transfer is checked against the oldest pending result. The outputs
    // are sampled at the clock edge, before the block updates them.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            scoreboard.check_result(o_kind, o_record_key, o_record_value, o_last_of_run);
        end
    end

    // The receiver stalls at random after each transfer, with stretches
    // of no stall at all. Twice it holds off for a long stretch so that the result
    // queue fills up and the block stalls its input while the sender keeps offering.
    initial begin : result_receiver
        int stall_left;
        int taken;
        stall_left = 0;
        taken      = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && !i_out_stall) begin
                taken++;
                if (taken == 40 || taken == 250) begin
                    stall_left = 48;
                end else if ((taken % 64) < 16) begin
                    stall_left = 0;
                end else begin
                    stall_left = $urandom_range(0, 3);
                end
            end
            if (stall_left > 0) begin
                i_out_stall <= 1'b1;
                stall_left--;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    // Appends an n-byte field in the current field order.
    function automatic void add_field(logic [63:0] value, int n);
        int idx;
        for (int i = 0; i < n; i++) begin
            idx = encode_big ? (n - 1 - i) : i;
            frame_bytes.push_back(value[8 * idx +: 8]);
        end
    endfunction

    function automatic void add_header(logic [12:0] key, logic [2:0] rec_type);
        add_field({48'd0, key, rec_type}, 2);
    endfunction

    function automatic logic [12:0] pick_key();
        case ($urandom_range(0, 5))
            0: return 13'd0;
            1: return 13'h1FFF;
            default: return 13'($urandom);
        endcase
    endfunction

    // Mostly random values, with zero, all ones and the int32 sign extremes mixed in.
    function automatic logic [63:0] pick_value();
        case ($urandom_range(0, 7))
            0: return 64'd0;
            1: return '1;
            2: return {2{32'h8000_0000}};
            3: return {2{32'h7FFF_FFFF}};
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic void add_random_record();
        logic [12:0] key;
        int          sel;
        int          len;
        key = pick_key();
        sel = $urandom_range(0, 9);
        if (sel < 3) begin
            add_header(key, kv_tlv_pkg::REC_INT32);
            add_field(pick_value(), 4);
        end else if (sel < 6) begin
            add_header(key, kv_tlv_pkg::REC_INT64);
            add_field(pick_value(), 8);
        end else begin
            // Payloads stay short; a few are longer to keep the payload phase busy.
            len = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 24) : $urandom_range(0, 5);
            add_header(key, kv_tlv_pkg::REC_BYTES);
            add_field(64'(len), 4);
            repeat (len) frame_bytes.push_back(8'($urandom));
        end
    endfunction

    // Builds one buffer. Most are well formed with random content; the rest are cut
    // short, carry an unknown record type, or are plain noise.
    function automatic void build_frame();
        int style;
        int cut;
        frame_bytes.delete();
        style = $urandom_range(0, 9);
        repeat ($urandom_range(1, 4)) add_random_record();
        if (style == 7) begin
            cut = $urandom_range(1, frame_bytes.size() - 1);
            frame_bytes = frame_bytes[0:cut - 1];
        end else if (style == 8) begin
            add_header(pick_key(), 3'($urandom_range(3, 7)));
            repeat ($urandom_range(0, 4)) frame_bytes.push_back(8'($urandom));
        end else if (style == 9) begin
            frame_bytes.delete();
            repeat ($urandom_range(1, 10)) frame_bytes.push_back(8'($urandom));
        end
    endfunction

    // Offers one byte and waits for its transfer. Valid stays high between
    // back-to-back bytes and is only lowered for a gap.
    task automatic send_byte(input logic [7:0] b, input logic eob);
        int gap;
        gap = sender_eager ? 0 : $urandom_range(0, 3);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_data_byte     <= b;
        i_end_of_buffer <= eob;
        do @(posedge i_clk); while (o_in_stall);
        scoreboard.parse_byte(b, eob);
    endtask

    task automatic send_frame();
        sender_eager = ($urandom_range(0, 3) == 0);
        foreach (frame_bytes[i]) begin
            send_byte(frame_bytes[i], i == frame_bytes.size() - 1);
        end
    endtask

    // Stops offering, waits until every pending result has come, and then waits on
    // for anything still inside the block.
    task automatic wait_drain();
        i_in_valid <= 1'b0;
        while (scoreboard.pending() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_order(input bit be);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= be;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        scoreboard.set_order(be);
        encode_big = be;
    endtask

    initial begin : stimulus
        int sent;
        int frames;
        bit be;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed buffers in the reset (big-endian) order.
        // The most negative int32 at the largest key, ending the buffer: record plus status.
        frame_bytes.delete();
        add_header(13'h1FFF, kv_tlv_pkg::REC_INT32);
        add_field(64'h8000_0000, 4);
        send_frame();
        // An int64 at key zero with only the sign bit set, also closing its buffer.
        frame_bytes.delete();
        add_header(13'd0, kv_tlv_pkg::REC_INT64);
        add_field(64'h8000_0000_0000_0000, 8);
        send_frame();
        // A bytes record of length zero gives only its header, then the ok status.
        frame_bytes.delete();
        add_header(13'h1FFF, kv_tlv_pkg::REC_BYTES);
        add_field(64'd0, 4);
        send_frame();
        // An unknown record type makes the buffer malformed.
        frame_bytes.delete();
        add_header(13'h0AAA, 3'd7);
        send_frame();
        // A buffer that ends inside the header is malformed too.
        frame_bytes.delete();
        frame_bytes.push_back(8'h5A);
        send_frame();

        // Random phases, alternating the field order so both register values are used.
        for (int p = 0; p < 4; p++) begin
            wait_drain();
            be = (p % 2 == 1);
            write_order(be);
            sent   = 0;
            frames = 0;
            while (sent < PHASE_BYTES) begin
                build_frame();
                send_frame();
                sent += frame_bytes.size();
                frames++;
                // Now and then the sender pauses until every result has been delivered.
                if (frames % 12 == 0) begin
                    wait_drain();
                end
            end
        end

        wait_drain();
        repeat (8) @(posedge i_clk);
        if (scoreboard.mismatches == 0 && scoreboard.pending() == 0) begin
            $display("kv_tlv_record_parser_unit_tb passed");
        end else begin
            $display("kv_tlv_record_parser_unit_tb failed");
        end
        $finish;
    end

endmodule
